[hdl/hvn_pkg.sv]
// shared types and constants for the heightmap vertex normal block
`default_nettype none
package hvn_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MAG_W      = 60;
  localparam int POS_W      = $clog2(MAG_W);
  localparam int NRM_W      = 30;
  localparam int SQ_W       = 62;
  localparam int LEN_W      = 31;
  localparam int Q_W        = 15;
  localparam int DIV_W      = 47;
  localparam int ONE_Q14    = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_STEP_X,
    REG_STEP_Z,
    REG_HEIGHT_SCALE
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [16:0]      step_x;
    logic [16:0]      step_z;
    logic [15:0]      height_scale;
  } cfg_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  height_center;
    logic [7:0]  height_up;
    logic [7:0]  height_right;
    logic [7:0]  height_down;
    logic [7:0]  height_left;
  } pix_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } cvec_t;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] m;
    logic [2:0]            neg;
    logic                  zero;
  } nvec_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               zero_normal;
  } nrm_out_t;

endpackage
`default_nettype wire

[hdl/hvn_if.sv]
// stream and configuration channel interfaces
`default_nettype none
interface hvn_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] column;
  logic [11:0] row;
  logic [7:0]  height_center;
  logic [7:0]  height_up;
  logic [7:0]  height_right;
  logic [7:0]  height_down;
  logic [7:0]  height_left;
  modport source (output valid, column, row, height_center, height_up, height_right,
                  height_down, height_left, input ready);
  modport sink (input valid, column, row, height_center, height_up, height_right,
                height_down, height_left, output ready);
endinterface

interface hvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               zero_normal;
  modport source (output valid, normal_x, normal_y, normal_z, zero_normal, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, zero_normal, output ready);
endinterface

interface hvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/hvn_front.sv]
// edge flags, neighbor differences and exact summed cross product magnitudes
`default_nettype none
module hvn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  hvn_pkg::pix_t pix,
  input  hvn_pkg::cfg_t cfg,
  output logic          vec_valid,
  output hvn_pkg::cvec_t vec
);
  import hvn_pkg::*;

  function automatic logic signed [11:0] scaled(input logic signed [8:0] d,
                                                 input logic [1:0] k);
    logic signed [11:0] r;
    r = 12'sd0;
    if (k == 2'd1) r = {{3{d[8]}}, d};
    else if (k == 2'd2) r = {{2{d[8]}}, d, 1'b0};
    return r;
  endfunction

  logic [DIM_W-1:0]   w_lim, h_lim;
  logic               up, right, down, left;
  logic               a_f, b_f, c_f, d_f;
  logic [1:0]         kl, kr, ku, kd;
  logic signed [8:0]  dl, dr, du, dd;
  logic signed [11:0] ex, ez;
  logic [10:0]        exm_nxt, ezm_nxt;
  logic [2:0]         n_nxt;

  logic [10:0] exm_r, ezm_r;
  logic        exn_r, ezn_r;
  logic [2:0]  n_r;
  logic [2:0]  v_r;

  logic [26:0] ax_nxt, az_nxt, ax_r, az_r;
  logic [33:0] sxz_nxt, sxz_r;
  logic [17:0] ky_nxt, ky_r;
  logic [24:0] sx255_nxt, sz255_nxt, sx255_r, sz255_r;
  logic        exn2_r, ezn2_r;

  logic [51:0] px, py, pz;
  cvec_t       vec_nxt, vec_r;

  always_comb begin
    w_lim = (cfg.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
    h_lim = (cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;
    up    = ({1'b0, pix.row} + 13'd1) < h_lim;
    right = ({1'b0, pix.column} + 13'd1) < w_lim;
    down  = pix.row != 12'd0;
    left  = pix.column != 12'd0;
    a_f   = up & right;
    b_f   = down & right;
    c_f   = down & left;
    d_f   = up & left;
    kl    = {1'b0, c_f} + {1'b0, d_f};
    kr    = {1'b0, a_f} + {1'b0, b_f};
    kd    = {1'b0, b_f} + {1'b0, c_f};
    ku    = {1'b0, a_f} + {1'b0, d_f};
    n_nxt = {2'b0, a_f} + {2'b0, b_f} + {2'b0, c_f} + {2'b0, d_f};
    dl    = $signed({1'b0, pix.height_left}) - $signed({1'b0, pix.height_center});
    dr    = $signed({1'b0, pix.height_right}) - $signed({1'b0, pix.height_center});
    du    = $signed({1'b0, pix.height_up}) - $signed({1'b0, pix.height_center});
    dd    = $signed({1'b0, pix.height_down}) - $signed({1'b0, pix.height_center});
    ex    = scaled(dl, kl) - scaled(dr, kr);
    ez    = scaled(dd, kd) - scaled(du, ku);
    exm_nxt = ex[11] ? 11'(-ex) : ex[10:0];
    ezm_nxt = ez[11] ? 11'(-ez) : ez[10:0];
  end

  always_comb begin
    ax_nxt    = exm_r * cfg.height_scale;
    az_nxt    = ezm_r * cfg.height_scale;
    sxz_nxt   = cfg.step_x * cfg.step_z;
    ky_nxt    = n_r * 18'd65025;
    sx255_nxt = {cfg.step_x, 8'b0} - {8'b0, cfg.step_x};
    sz255_nxt = {cfg.step_z, 8'b0} - {8'b0, cfg.step_z};
  end

  always_comb begin
    px = ax_r * sz255_r;
    pz = az_r * sx255_r;
    py = sxz_r * ky_r;
    vec_nxt.mag[0] = {px, 8'b0};
    vec_nxt.mag[1] = {8'b0, py};
    vec_nxt.mag[2] = {pz, 8'b0};
    vec_nxt.neg    = {ezn2_r, 1'b0, exn2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exm_r   <= exm_nxt;
      ezm_r   <= ezm_nxt;
      exn_r   <= ex[11];
      ezn_r   <= ez[11];
      n_r     <= n_nxt;
      ax_r    <= ax_nxt;
      az_r    <= az_nxt;
      sxz_r   <= sxz_nxt;
      ky_r    <= ky_nxt;
      sx255_r <= sx255_nxt;
      sz255_r <= sz255_nxt;
      exn2_r  <= exn_r;
      ezn2_r  <= ezn_r;
      vec_r   <= vec_nxt;
    end
  end

  assign vec_valid = v_r[2];
  assign vec       = vec_r;

endmodule
`default_nettype wire

[hdl/hvn_norm.sv]
// common exponent shift, squares and sum of squares
`default_nettype none
module hvn_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vec_valid,
  input  hvn_pkg::cvec_t  vec,
  output logic            sum_valid,
  output logic [hvn_pkg::SQ_W-1:0] sum,
  output hvn_pkg::nvec_t  nv
);
  import hvn_pkg::*;

  logic [MAG_W-1:0] orv;
  logic [POS_W-1:0] pos_nxt, pos_r;
  cvec_t            vec4_r;
  logic             zero4_r;
  nvec_t            nv5_nxt, nv5_r, nv6_r, nv7_r;
  logic [2:0][2*NRM_W-1:0] sq_nxt, sq_r;
  logic [SQ_W-1:0]  sum_nxt, sum_r;
  logic [3:0]       v_r;

  always_comb begin
    orv     = vec.mag[0] | vec.mag[1] | vec.mag[2];
    pos_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) pos_nxt = POS_W'(i);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (pos_r >= POS_W'(NRM_W - 1)) begin
        nv5_nxt.m[j] = NRM_W'(vec4_r.mag[j] >> (pos_r - POS_W'(NRM_W - 1)));
      end else begin
        nv5_nxt.m[j] = NRM_W'(vec4_r.mag[j] << (POS_W'(NRM_W - 1) - pos_r));
      end
    end
    nv5_nxt.neg  = vec4_r.neg;
    nv5_nxt.zero = zero4_r;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_nxt[j] = nv5_r.m[j] * nv5_r.m[j];
    end
    sum_nxt = SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], vec_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec4_r  <= vec;
      pos_r   <= pos_nxt;
      zero4_r <= orv == '0;
      nv5_r   <= nv5_nxt;
      sq_r    <= sq_nxt;
      nv6_r   <= nv5_r;
      sum_r   <= sum_nxt;
      nv7_r   <= nv6_r;
    end
  end

  assign sum_valid = v_r[3];
  assign sum       = sum_r;
  assign nv        = nv7_r;

endmodule
`default_nettype wire

[hdl/hvn_sqrt.sv]
// pipelined integer square root, one result bit per stage
`default_nettype none
module hvn_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      sum_valid,
  input  logic [hvn_pkg::SQ_W-1:0]  sum,
  input  hvn_pkg::nvec_t            nv_in,
  output logic                      len_valid,
  output logic [hvn_pkg::LEN_W-1:0] len,
  output hvn_pkg::nvec_t            nv_out
);
  import hvn_pkg::*;

  logic [SQ_W-1:0]  rem_r   [LEN_W];
  logic [SQ_W-1:0]  rem_nxt [LEN_W];
  logic [LEN_W-1:0] res_r   [LEN_W];
  logic [LEN_W-1:0] res_nxt [LEN_W];
  nvec_t            nv_r    [LEN_W];
  nvec_t            nv_nxt  [LEN_W];
  logic [LEN_W-1:0] v_r, v_nxt;

  always_comb begin
    logic [SQ_W-1:0]  rem;
    logic [LEN_W-1:0] res;
    logic [63:0]      trial;
    for (int k = 0; k < LEN_W; k++) begin
      if (k == 0) begin
        rem       = sum;
        res       = '0;
        nv_nxt[k] = nv_in;
        v_nxt[k]  = sum_valid;
      end else begin
        rem       = rem_r[k-1];
        res       = res_r[k-1];
        nv_nxt[k] = nv_r[k-1];
        v_nxt[k]  = v_r[k-1];
      end
      trial = ({33'b0, res} << (LEN_W - k)) | (64'd1 << (2 * (LEN_W - 1 - k)));
      if ({2'b0, rem} >= trial) begin
        rem = rem - trial[SQ_W-1:0];
        res = res | (LEN_W'(1) << (LEN_W - 1 - k));
      end
      rem_nxt[k] = rem;
      res_nxt[k] = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LEN_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        res_r[k] <= res_nxt[k];
        nv_r[k]  <= nv_nxt[k];
      end
    end
  end

  assign len_valid = v_r[LEN_W-1];
  assign len       = res_r[LEN_W-1];
  assign nv_out    = nv_r[LEN_W-1];

endmodule
`default_nettype wire

[hdl/hvn_div.sv]
// pipelined rounding divide by the length and the output register
`default_nettype none
module hvn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      len_valid,
  input  logic [hvn_pkg::LEN_W-1:0] len,
  input  hvn_pkg::nvec_t            nv,
  output logic                      out_valid,
  output hvn_pkg::nrm_out_t         out_item
);
  import hvn_pkg::*;

  logic [2:0][DIV_W-1:0] rem_r   [Q_W+1];
  logic [2:0][DIV_W-1:0] rem_nxt [Q_W+1];
  logic [2:0][Q_W-1:0]   q_r     [Q_W+1];
  logic [2:0][Q_W-1:0]   q_nxt   [Q_W+1];
  logic [LEN_W-1:0]      d_r     [Q_W+1];
  logic [LEN_W-1:0]      d_nxt   [Q_W+1];
  logic [2:0]            neg_r   [Q_W+1];
  logic [2:0]            neg_nxt [Q_W+1];
  logic [Q_W:0]          zero_r, zero_nxt;
  logic [Q_W:0]          v_r, v_nxt;
  logic                  out_valid_r;
  nrm_out_t              out_nxt, out_r;
  logic [2:0][15:0]      comp;

  always_comb begin
    logic [DIV_W-1:0] t;
    for (int k = 0; k <= Q_W; k++) begin
      if (k == 0) begin
        for (int j = 0; j < 3; j++) begin
          rem_nxt[k][j] = DIV_W'({nv.m[j], {Q_W{1'b0}}}) + DIV_W'(len);
          q_nxt[k][j]   = '0;
        end
        d_nxt[k]    = len;
        neg_nxt[k]  = nv.neg;
        zero_nxt[k] = nv.zero;
        v_nxt[k]    = len_valid;
      end else begin
        t = DIV_W'(d_r[k-1]) << (Q_W - k + 1);
        for (int j = 0; j < 3; j++) begin
          rem_nxt[k][j] = rem_r[k-1][j];
          q_nxt[k][j]   = q_r[k-1][j];
          if (rem_r[k-1][j] >= t) begin
            rem_nxt[k][j] = rem_r[k-1][j] - t;
            q_nxt[k][j]   = q_r[k-1][j] | (Q_W'(1) << (Q_W - k));
          end
        end
        d_nxt[k]    = d_r[k-1];
        neg_nxt[k]  = neg_r[k-1];
        zero_nxt[k] = zero_r[k-1];
        v_nxt[k]    = v_r[k-1];
      end
    end
  end

  always_comb begin
    logic [15:0] qq;
    for (int j = 0; j < 3; j++) begin
      qq = (q_r[Q_W][j] > Q_W'(ONE_Q14)) ? 16'(ONE_Q14) : {1'b0, q_r[Q_W][j]};
      if (zero_r[Q_W]) comp[j] = '0;
      else if (neg_r[Q_W][j]) comp[j] = -qq;
      else comp[j] = qq;
    end
    out_nxt.normal_x    = comp[0];
    out_nxt.normal_y    = comp[1];
    out_nxt.normal_z    = comp[2];
    out_nxt.zero_normal = zero_r[Q_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= v_nxt;
      out_valid_r <= v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_nxt[k];
        neg_r[k] <= neg_nxt[k];
      end
      zero_r <= zero_nxt;
      out_r  <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

[hdl/heightmap_vertex_normal.sv]
// Heightmap vertex normal: one pixel with its four neighbor heights in,
// one signed Q1.14 unit normal out.
// in_ch carries column, row and five 8-bit heights; out_ch carries
// normal_x/y/z and zero_normal; cfg_ch writes image_width (0), image_height (1),
// step_x (2), step_z (3) and height_scale (4) and is always ready.
// Stages from an input transfer to the result standing in the output
// register: 3 for edge flags and products, 4 for shift and squares,
// 31 for the square root (one bit per stage), 16 for the divide (a
// rounding stage, then one quotient bit per stage) and 1 for sign and output.
// Throughput is one pixel per cycle unless out_ch stalls; every stage is registered.
// Reset clears all valid bits and loads 256 into every configuration register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops in the same cycle; nothing is dropped or repeated.
`default_nettype none
module heightmap_vertex_normal (
  input  logic       clk,
  input  logic       rst_n,
  hvn_in_if.sink     in_ch,
  hvn_out_if.source  out_ch,
  hvn_cfg_if.sink    cfg_ch
);
  import hvn_pkg::*;

  cfg_t              cfg_r;
  pix_t              pix;
  logic              en;
  logic              vec_valid, sum_valid, len_valid, out_valid;
  cvec_t             vec;
  logic [SQ_W-1:0]   sum;
  nvec_t             nv_a, nv_b;
  logic [LEN_W-1:0]  len;
  nrm_out_t          out_item;

  assign en           = ~out_valid | out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= DIM_W'(256);
      cfg_r.image_height <= DIM_W'(256);
      cfg_r.step_x       <= 17'd256;
      cfg_r.step_z       <= 17'd256;
      cfg_r.height_scale <= 16'd256;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_ch.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_ch.data[DIM_W-1:0];
        REG_STEP_X:       cfg_r.step_x       <= cfg_ch.data;
        REG_STEP_Z:       cfg_r.step_z       <= cfg_ch.data;
        REG_HEIGHT_SCALE: cfg_r.height_scale <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pix.column        = in_ch.column;
    pix.row           = in_ch.row;
    pix.height_center = in_ch.height_center;
    pix.height_up     = in_ch.height_up;
    pix.height_right  = in_ch.height_right;
    pix.height_down   = in_ch.height_down;
    pix.height_left   = in_ch.height_left;
  end

  hvn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .pix       (pix),
    .cfg       (cfg_r),
    .vec_valid (vec_valid),
    .vec       (vec)
  );

  hvn_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vec_valid (vec_valid),
    .vec       (vec),
    .sum_valid (sum_valid),
    .sum       (sum),
    .nv        (nv_a)
  );

  hvn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .sum_valid (sum_valid),
    .sum       (sum),
    .nv_in     (nv_a),
    .len_valid (len_valid),
    .len       (len),
    .nv_out    (nv_b)
  );

  hvn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .len_valid (len_valid),
    .len       (len),
    .nv        (nv_b),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.normal_x    = out_item.normal_x;
  assign out_ch.normal_y    = out_item.normal_y;
  assign out_ch.normal_z    = out_item.normal_z;
  assign out_ch.zero_normal = out_item.zero_normal;

endmodule
`default_nettype wire

[hdl/hvn_chk.sv]
// port-level checker for the heightmap vertex normal block and its bind
`default_nettype none
module hvn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] normal_x,
  input logic [15:0] normal_y,
  input logic [15:0] normal_z,
  input logic        zero_normal
);

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled output holds the input side
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // zero flag comes with a zero vector
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_normal |-> normal_x == 16'd0 && normal_y == 16'd0 &&
                                 normal_z == 16'd0)
    else $error("zero flag with nonzero normal");

endmodule

bind heightmap_vertex_normal hvn_chk u_hvn_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .normal_x    (out_ch.normal_x),
  .normal_y    (out_ch.normal_y),
  .normal_z    (out_ch.normal_z),
  .zero_normal (out_ch.zero_normal)
);
`default_nettype wire
